@@ sv/wait_queue_with_id_removal_defines.svh @@
// Assertion macros shared by the checkers of the wait queue block.
// Every macro expects clk_i and rst_ni in the scope where it is used.
`ifndef WAIT_QUEUE_WITH_ID_REMOVAL_DEFINES_SVH
`define WAIT_QUEUE_WITH_ID_REMOVAL_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WQIR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WQIR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/wqir_pkg.sv @@
// Shared types, constants and helpers of the wait queue block.
// Used by the sequencer, the output stage and the checker; depends on nothing.
package wqir_pkg;

  localparam int unsigned DEPTH   = 16;
  localparam int unsigned ID_BITS = 16;

  // Field widths of the stream words.
  localparam int unsigned ID_W   = 16;
  localparam int unsigned ACT_W  = 3;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned OCC_W  = 5;

  // Stored identifier width: the field masked down to ID_BITS.
  localparam int unsigned SID_W = (ID_BITS < ID_W) ? ID_BITS : ID_W;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned IN_TUSER_W  = ACT_W;
  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned OUT_TUSER_W = STAT_W + 1;

  typedef enum logic [ACT_W-1:0] {
    ACT_APPEND      = 3'd0,
    ACT_REMOVE_HEAD = 3'd1,
    ACT_REMOVE_ID   = 3'd2,
    ACT_PEEK        = 3'd3,
    ACT_LOOKUP      = 3'd4,
    ACT_RELEASE     = 3'd5
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_HEAD,
    S_SEARCH,
    S_SHIFT
  } state_e;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    status_e          status;
    logic             released;
    logic [OCC_W-1:0] occupancy;
    logic             last;
  } result_t;

  // Physical slot of a logical position in the circular store.
  function automatic logic [PTR_W-1:0] wrap_add(logic [PTR_W-1:0] base,
                                                logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(DEPTH)) begin
      sum = sum - (CNT_W+1)'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

@@ sv/wait_queue_with_id_removal.sv @@
// Top level of the wait queue: sequencer, circular identifier store and output stage.
// Depends on wqir_pkg and wqir_out_stage.
//
// Usage: each input word carries an action in s_axis_tuser and an identifier in
// s_axis_tdata. The queue keeps up to DEPTH identifiers in arrival order in a
// circular store addressed from a head pointer. Results leave on the m_axis
// channel; a release-all on a non-empty queue gives one word per entry with
// tlast on the final one, every other action gives a single word with tlast set.
// Append writes the tail slot directly. Peek, remove-head and release-all
// first read the head entry. A lookup or a remove-by-id reads the entries
// from the head in turn and compares each with the requested identifier; a
// removal then moves each later entry down one slot toward the head.
// Release-all gives one word per cycle while the receiver takes them.
// All work runs through one read port and one identifier comparator, so the
// next item is accepted once the sequencer is back to idle. Action codes six
// and seven are taken and dropped without a result.
// Reset empties the queue at once; the store is not cleared, entries are
// only read below the fill count. When the receiver stalls, the sequencer
// waits with its next word, while a word that still waits in the output
// register does not keep a new input word from being accepted.
module wait_queue_with_id_removal (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // item_id
  input  logic [wqir_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // action
  input  logic [wqir_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // result_id, occupancy, zero padding
  output logic [wqir_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // status, released
  output logic [wqir_pkg::OUT_TUSER_W-1:0]   m_axis_tuser,
  output logic                               m_axis_tlast
);

  wqir_pkg::state_e state_q, state_d;
  logic [wqir_pkg::PTR_W-1:0] head_q, head_d;
  logic [wqir_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [wqir_pkg::PTR_W-1:0] idx_q, idx_d;
  logic [wqir_pkg::ACT_W-1:0] act_q, act_d;
  logic [wqir_pkg::SID_W-1:0] id_q, id_d;

  logic [wqir_pkg::SID_W-1:0] mem [wqir_pkg::DEPTH];
  logic                       rd_en, wr_en;
  logic [wqir_pkg::PTR_W-1:0] rd_addr, wr_addr;
  logic [wqir_pkg::SID_W-1:0] rd_data_q, wr_data;

  logic                       emit, slot_free, accept;
  wqir_pkg::result_t          res;

  logic [wqir_pkg::CNT_W-1:0] cnt_m1, idx_ext, idx_p1;
  logic [wqir_pkg::PTR_W-1:0] head_next;
  logic                       last_idx, hit;

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == wqir_pkg::S_IDLE);
  assign cnt_m1    = cnt_q - wqir_pkg::CNT_W'(1);
  assign idx_ext   = wqir_pkg::CNT_W'(idx_q);
  assign idx_p1    = idx_ext + wqir_pkg::CNT_W'(1);
  assign head_next = wqir_pkg::wrap_add(head_q, wqir_pkg::CNT_W'(1));
  assign last_idx  = (idx_ext == cnt_m1);
  // The one shared comparator: stored entry against the requested identifier.
  assign hit       = (rd_data_q == id_q);

  always_comb begin
    state_d = state_q;
    head_d  = head_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    act_d   = act_q;
    id_d    = id_q;
    rd_en   = 1'b0;
    rd_addr = head_q;
    wr_en   = 1'b0;
    wr_addr = head_q;
    wr_data = id_q;
    emit    = 1'b0;
    res     = '0;
    res.status    = wqir_pkg::STAT_OK;
    res.last      = 1'b1;
    res.occupancy = wqir_pkg::OCC_W'(cnt_q);

    unique case (state_q)
      wqir_pkg::S_IDLE: begin
        if (accept) begin
          act_d = s_axis_tuser;
          id_d  = s_axis_tdata[wqir_pkg::SID_W-1:0];
          idx_d = '0;
          if (s_axis_tuser <= wqir_pkg::ACT_RELEASE) begin
            state_d = wqir_pkg::S_DISPATCH;
          end
        end
      end

      wqir_pkg::S_DISPATCH: begin
        unique case (act_q)
          wqir_pkg::ACT_APPEND: begin
            if (slot_free) begin
              emit    = 1'b1;
              state_d = wqir_pkg::S_IDLE;
              if (cnt_q == wqir_pkg::CNT_W'(wqir_pkg::DEPTH)) begin
                res.status = wqir_pkg::STAT_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = wqir_pkg::wrap_add(head_q, cnt_q);
                wr_data = id_q;
                cnt_d   = cnt_q + wqir_pkg::CNT_W'(1);
                res.occupancy = wqir_pkg::OCC_W'(cnt_q + wqir_pkg::CNT_W'(1));
              end
            end
          end
          wqir_pkg::ACT_REMOVE_HEAD, wqir_pkg::ACT_PEEK, wqir_pkg::ACT_RELEASE,
          wqir_pkg::ACT_REMOVE_ID, wqir_pkg::ACT_LOOKUP: begin
            if (cnt_q == '0) begin
              if (slot_free) begin
                emit       = 1'b1;
                res.status = wqir_pkg::STAT_MISS;
                state_d    = wqir_pkg::S_IDLE;
              end
            end else begin
              rd_en   = 1'b1;
              rd_addr = head_q;
              if (act_q == wqir_pkg::ACT_REMOVE_ID || act_q == wqir_pkg::ACT_LOOKUP) begin
                state_d = wqir_pkg::S_SEARCH;
              end else begin
                state_d = wqir_pkg::S_HEAD;
              end
            end
          end
          default: state_d = wqir_pkg::S_IDLE;
        endcase
      end

      wqir_pkg::S_HEAD: begin
        if (slot_free) begin
          emit   = 1'b1;
          res.id = wqir_pkg::ID_W'(rd_data_q);
          if (act_q == wqir_pkg::ACT_PEEK) begin
            state_d = wqir_pkg::S_IDLE;
          end else begin
            head_d        = head_next;
            cnt_d         = cnt_m1;
            res.occupancy = wqir_pkg::OCC_W'(cnt_m1);
            if (act_q == wqir_pkg::ACT_RELEASE) begin
              res.released = 1'b1;
              res.last     = (cnt_m1 == '0);
              // A release goes on until the fill count reaches zero, so it
              // always drains the queue completely.
              if (cnt_m1 != '0) begin
                rd_en   = 1'b1;
                rd_addr = head_next;
              end else begin
                state_d = wqir_pkg::S_IDLE;
              end
            end else begin
              state_d = wqir_pkg::S_IDLE;
            end
          end
        end
      end

      wqir_pkg::S_SEARCH: begin
        if (hit && act_q == wqir_pkg::ACT_LOOKUP) begin
          if (slot_free) begin
            emit    = 1'b1;
            res.id  = wqir_pkg::ID_W'(id_q);
            state_d = wqir_pkg::S_IDLE;
          end
        end else if (last_idx) begin
          if (slot_free) begin
            emit    = 1'b1;
            state_d = wqir_pkg::S_IDLE;
            if (hit) begin
              res.id        = wqir_pkg::ID_W'(id_q);
              res.occupancy = wqir_pkg::OCC_W'(cnt_m1);
              cnt_d         = cnt_m1;
            end else begin
              res.status = wqir_pkg::STAT_MISS;
            end
          end
        end else begin
          // Fetch the next entry while this one is compared.
          rd_en   = 1'b1;
          rd_addr = wqir_pkg::wrap_add(head_q, idx_p1);
          idx_d   = wqir_pkg::PTR_W'(idx_p1);
          if (hit) begin
            state_d = wqir_pkg::S_SHIFT;
          end
        end
      end

      wqir_pkg::S_SHIFT: begin
        // Move the entry read last cycle one slot toward the head.
        wr_en   = 1'b1;
        wr_addr = wqir_pkg::wrap_add(head_q, idx_ext - wqir_pkg::CNT_W'(1));
        wr_data = rd_data_q;
        if (last_idx) begin
          if (slot_free) begin
            emit          = 1'b1;
            res.id        = wqir_pkg::ID_W'(id_q);
            res.occupancy = wqir_pkg::OCC_W'(cnt_m1);
            cnt_d         = cnt_m1;
            state_d       = wqir_pkg::S_IDLE;
          end
        end else begin
          rd_en   = 1'b1;
          rd_addr = wqir_pkg::wrap_add(head_q, idx_p1);
          idx_d   = wqir_pkg::PTR_W'(idx_p1);
        end
      end

      default: state_d = wqir_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wqir_pkg::S_IDLE;
      head_q  <= '0;
      cnt_q   <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q <= act_d;
    id_q  <= id_d;
  end

  // Identifier store: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  wqir_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (emit),
    .result_i    (res),
    .slot_free_o (slot_free),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_o   (m_axis_tdata),
    .m_tuser_o   (m_axis_tuser),
    .m_tlast_o   (m_axis_tlast)
  );

endmodule

@@ sv/wqir_out_stage.sv @@
// Output register of the wait queue: holds one result word for the receiver.
// Depends on wqir_pkg for the result struct and the stream word layout.
module wqir_out_stage (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               load_i,
  input  wqir_pkg::result_t                  result_i,
  output logic                               slot_free_o,
  output logic                               m_tvalid_o,
  input  logic                               m_tready_i,
  output logic [wqir_pkg::OUT_TDATA_W-1:0]   m_tdata_o,
  output logic [wqir_pkg::OUT_TUSER_W-1:0]   m_tuser_o,
  output logic                               m_tlast_o
);

  logic              valid_q, valid_d;
  wqir_pkg::result_t res_q;

  // The slot frees up in the same cycle the receiver takes the held word.
  assign slot_free_o = !valid_q || m_tready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_tready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  assign m_tvalid_o = valid_q;
  assign m_tdata_o  = {{(wqir_pkg::OUT_TDATA_W - wqir_pkg::ID_W - wqir_pkg::OCC_W){1'b0}},
                       res_q.occupancy, res_q.id};
  assign m_tuser_o  = {res_q.released, res_q.status};
  assign m_tlast_o  = res_q.last;

endmodule

@@ sv/wqir_checker.sv @@
// Port-level checks of the wait queue, bound to the top level.
// Depends on wqir_pkg and wait_queue_with_id_removal_defines.svh.
`include "wait_queue_with_id_removal_defines.svh"

module wqir_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic [wqir_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [wqir_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input logic [wqir_pkg::OUT_TUSER_W-1:0]   m_axis_tuser,
  input logic                               m_axis_tlast
);

  logic [wqir_pkg::OCC_W-1:0]  occ;
  logic [wqir_pkg::STAT_W-1:0] stat;
  logic                        rel, out_word, valid_in, out_stall;
  logic [wqir_pkg::OUT_TDATA_W+wqir_pkg::OUT_TUSER_W:0] out_bus;

  assign occ       = m_axis_tdata[wqir_pkg::ID_W +: wqir_pkg::OCC_W];
  assign stat      = m_axis_tuser[wqir_pkg::STAT_W-1:0];
  assign rel       = m_axis_tuser[wqir_pkg::STAT_W];
  assign out_word  = m_axis_tvalid;
  assign out_stall = out_word && !m_axis_tready;
  assign out_bus   = {m_axis_tlast, m_axis_tuser, m_axis_tdata};
  assign valid_in  = s_axis_tvalid && s_axis_tready &&
                     (s_axis_tuser <= wqir_pkg::ACT_RELEASE);

  // A stalled result word must stay put.
  `WQIR_ASSERT_NEXT(a_out_hold, out_stall, out_word && $stable(out_bus), "stalled result word changed")

  // A released identifier always comes with an ok status.
  `WQIR_ASSERT_NOW(a_rel_ok, out_word && rel, stat == wqir_pkg::STAT_OK, "released word without ok status")

  // The reported occupancy never exceeds the queue depth.
  `WQIR_ASSERT_NOW(a_occ_range, out_word, occ <= wqir_pkg::OCC_W'(wqir_pkg::DEPTH), "occupancy above depth")

  // A release run only continues while entries remain.
  `WQIR_ASSERT_NOW(a_run_rest, out_word && rel && !m_axis_tlast, occ != '0, "release run on empty queue")

  // The sequencer is busy right after taking a valid action.
  `WQIR_ASSERT_NEXT(a_busy, valid_in, !s_axis_tready, "input ready right after a valid action")

endmodule

bind wait_queue_with_id_removal wqir_checker u_wqir_checker (.*);
